>>> rtl/idq_pkg.sv
`timescale 1ns / 1ps

package idq_pkg;

   // Bounds of the capacity parameter; cell positions are compared at the
   // width that the largest capacity needs.
   localparam int CAPACITY_MAX = 65536;
   localparam int POS_W = $clog2(CAPACITY_MAX + 1);

   localparam int CAPACITY_DEFAULT = 256;
   localparam int WORD_WIDTH_DEFAULT = 32;

   localparam int OP_W = 4;
   localparam int REQ_POS_W = 8;
   localparam int STATUS_W = 2;

   localparam logic [OP_W-1:0] OP_PUSH_FRONT = 4'd0;
   localparam logic [OP_W-1:0] OP_PUSH_BACK = 4'd1;
   localparam logic [OP_W-1:0] OP_INSERT = 4'd2;
   localparam logic [OP_W-1:0] OP_POP_FRONT = 4'd3;
   localparam logic [OP_W-1:0] OP_POP_BACK = 4'd4;
   localparam logic [OP_W-1:0] OP_REMOVE = 4'd5;
   localparam logic [OP_W-1:0] OP_READ = 4'd6;
   localparam logic [OP_W-1:0] OP_WRITE = 4'd7;
   localparam logic [OP_W-1:0] OP_CLEAR = 4'd8;

   localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL = 2'd3;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_REMOVE,
      CELL_WRITE
   } cell_op_type;

   // Broadcast to every cell of the row.
   typedef struct packed {
      cell_op_type op;
      logic [POS_W-1:0] pos;
   } cell_cmd_type;

endpackage

>>> rtl/idq_cell.sv
`timescale 1ns / 1ps

module idq_cell #(
   parameter int INDEX = 0,
   parameter int WORD_WIDTH = idq_pkg::WORD_WIDTH_DEFAULT
) (
   input  logic                      clock,
   input  idq_pkg::cell_cmd_type     cmd,
   input  logic [WORD_WIDTH-1:0]     new_word,
   input  logic [WORD_WIDTH-1:0]     left_word,
   input  logic [WORD_WIDTH-1:0]     right_word,
   output logic [WORD_WIDTH-1:0]     stored_word,
   output logic [WORD_WIDTH-1:0]     pick_word
);

   localparam logic [idq_pkg::POS_W-1:0] MY_POS = idq_pkg::POS_W'(INDEX);

   logic [WORD_WIDTH-1:0] stored_ff;
   logic [WORD_WIDTH-1:0] stored_in;

   // Insert opens a gap at the given position by moving later words up one
   // cell; remove closes it by moving them down.
   always_comb begin
      stored_in = stored_ff;
      case (cmd.op)
         idq_pkg::CELL_INSERT: begin
            if (MY_POS > cmd.pos) begin
               stored_in = left_word;
            end else if (MY_POS == cmd.pos) begin
               stored_in = new_word;
            end
         end
         idq_pkg::CELL_REMOVE: begin
            if (MY_POS >= cmd.pos) begin
               stored_in = right_word;
            end
         end
         idq_pkg::CELL_WRITE: begin
            if (MY_POS == cmd.pos) begin
               stored_in = new_word;
            end
         end
         default: begin
            stored_in = stored_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      stored_ff <= stored_in;
   end

   assign stored_word = stored_ff;
   assign pick_word = (MY_POS == cmd.pos) ? stored_ff : '0;

endmodule

>>> rtl/idq_gather.sv
`timescale 1ns / 1ps

module idq_gather #(
   parameter int CAPACITY = idq_pkg::CAPACITY_DEFAULT,
   parameter int WORD_WIDTH = idq_pkg::WORD_WIDTH_DEFAULT
) (
   input  logic                  clock,
   input  logic [WORD_WIDTH-1:0] leaf_words [CAPACITY],
   output logic [WORD_WIDTH-1:0] root_word
);

   localparam int LAT = $clog2(CAPACITY);
   localparam int LEAVES = 1 << LAT;

   logic [WORD_WIDTH-1:0] leaf_pad [LEAVES];
   logic [WORD_WIDTH-1:0] node_ff [1:LEAVES-1];

   for (genvar g = 0; g < LEAVES; g++) begin : g_pad
      if (g < CAPACITY) begin : g_real
         assign leaf_pad[g] = leaf_words[g];
      end else begin : g_zero
         assign leaf_pad[g] = '0;
      end
   end

   // Binary OR tree, one register per node; at most one leaf is nonzero,
   // so the root holds the selected word once it has passed up through every level.
   for (genvar k = 1; k < LEAVES; k++) begin : g_node
      if (2 * k >= LEAVES) begin : g_low
         always_ff @(posedge clock) begin
            node_ff[k] <= leaf_pad[2*k-LEAVES] | leaf_pad[2*k+1-LEAVES];
         end
      end else begin : g_high
         always_ff @(posedge clock) begin
            node_ff[k] <= node_ff[2*k] | node_ff[2*k+1];
         end
      end
   end

   assign root_word = node_ff[1];

endmodule

>>> rtl/indexed_double_ended_queue.sv
`timescale 1ns / 1ps

// Bounded double-ended queue of CAPACITY words held in a row of cells, cell i
// holding the element at position i from the front.
// Input channel: a word (operation, position, word_in) is taken on a rising
// edge where start is high and busy is low; busy stays high until the result
// has been issued. Result channel: rsp_strobe is high for exactly one cycle
// with word_out, status and occupancy; the receiver cannot stall it.
// Operations that return no stored word (push, insert, write, clear, and
// every error) go from acceptance straight to the execute state, the next
// word being taken in the cycle the result shows. Pop, remove and read
// first pass through a gather state while the word is collected through a
// registered OR tree with one level per cycle.
// Insert and remove move all later words by one cell, all in the same cycle.
// Reset clears the element count; stored words need no clearing since only
// occupied cells are ever returned.
module indexed_double_ended_queue #(
   parameter int CAPACITY = idq_pkg::CAPACITY_DEFAULT,
   parameter int WORD_WIDTH = idq_pkg::WORD_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [idq_pkg::OP_W-1:0]            req_operation,
   input  logic [idq_pkg::REQ_POS_W-1:0]       req_position,
   input  logic [WORD_WIDTH-1:0]               req_word_in,
   output logic                                rsp_strobe,
   output logic [WORD_WIDTH-1:0]               rsp_word_out,
   output logic [idq_pkg::STATUS_W-1:0]        rsp_status,
   output logic [$clog2(CAPACITY+1)-1:0]       rsp_occupancy
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int POS_W = idq_pkg::POS_W;
   localparam int LAT = $clog2(CAPACITY);
   localparam int WAIT_W = (LAT > 1) ? $clog2(LAT) : 1;

   typedef enum logic [1:0] {
      IDLE,
      GATHER,
      EXEC
   } state_type;

   state_type state_ff;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_nxt_ff;
   logic [WAIT_W-1:0] wait_ff;
   logic [idq_pkg::STATUS_W-1:0] status_ff;
   idq_pkg::cell_op_type act_ff;
   logic [POS_W-1:0] pos_ff;
   logic [WORD_WIDTH-1:0] word_ff;
   logic read_ff;
   logic rsp_strobe_ff;
   logic [WORD_WIDTH-1:0] rsp_word_ff;
   logic [idq_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [CNT_W-1:0] rsp_occupancy_ff;

   logic [idq_pkg::STATUS_W-1:0] dec_status;
   idq_pkg::cell_op_type dec_op;
   logic [POS_W-1:0] dec_pos;
   logic dec_read;
   logic [CNT_W-1:0] dec_count;
   logic [POS_W-1:0] pos_x;
   logic [POS_W-1:0] cnt_x;
   logic is_full;
   logic is_empty;

   idq_pkg::cell_cmd_type cmd;
   logic [WORD_WIDTH-1:0] cell_word [CAPACITY];
   logic [WORD_WIDTH-1:0] pick_word [CAPACITY];
   logic [WORD_WIDTH-1:0] root_word;

   // Decode of the incoming word against the current element count.
   always_comb begin
      pos_x = POS_W'(req_position);
      cnt_x = POS_W'(count_ff);
      is_full = (count_ff == CNT_W'(CAPACITY));
      is_empty = (count_ff == '0);
      dec_status = idq_pkg::ST_OK;
      dec_op = idq_pkg::CELL_HOLD;
      dec_pos = pos_x;
      dec_read = 1'b0;
      dec_count = count_ff;
      case (req_operation)
         idq_pkg::OP_PUSH_FRONT: begin
            if (is_full) begin
               dec_status = idq_pkg::ST_FULL;
            end else begin
               dec_op = idq_pkg::CELL_INSERT;
               dec_pos = '0;
               dec_count = count_ff + 1'b1;
            end
         end
         idq_pkg::OP_PUSH_BACK: begin
            if (is_full) begin
               dec_status = idq_pkg::ST_FULL;
            end else begin
               dec_op = idq_pkg::CELL_INSERT;
               dec_pos = cnt_x;
               dec_count = count_ff + 1'b1;
            end
         end
         idq_pkg::OP_INSERT: begin
            if (is_empty) begin
               if (pos_x != '0) begin
                  dec_status = idq_pkg::ST_RANGE;
               end else begin
                  dec_op = idq_pkg::CELL_INSERT;
                  dec_count = count_ff + 1'b1;
               end
            end else if (pos_x >= cnt_x) begin
               dec_status = idq_pkg::ST_RANGE;
            end else if (is_full) begin
               dec_status = idq_pkg::ST_FULL;
            end else begin
               dec_op = idq_pkg::CELL_INSERT;
               dec_count = count_ff + 1'b1;
            end
         end
         idq_pkg::OP_POP_FRONT: begin
            if (is_empty) begin
               dec_status = idq_pkg::ST_EMPTY;
            end else begin
               dec_op = idq_pkg::CELL_REMOVE;
               dec_pos = '0;
               dec_read = 1'b1;
               dec_count = count_ff - 1'b1;
            end
         end
         idq_pkg::OP_POP_BACK: begin
            if (is_empty) begin
               dec_status = idq_pkg::ST_EMPTY;
            end else begin
               dec_op = idq_pkg::CELL_REMOVE;
               dec_pos = cnt_x - 1'b1;
               dec_read = 1'b1;
               dec_count = count_ff - 1'b1;
            end
         end
         idq_pkg::OP_REMOVE: begin
            if (is_empty) begin
               dec_status = idq_pkg::ST_EMPTY;
            end else if (pos_x >= cnt_x) begin
               dec_status = idq_pkg::ST_RANGE;
            end else begin
               dec_op = idq_pkg::CELL_REMOVE;
               dec_read = 1'b1;
               dec_count = count_ff - 1'b1;
            end
         end
         idq_pkg::OP_READ: begin
            if (is_empty) begin
               dec_status = idq_pkg::ST_EMPTY;
            end else if (pos_x >= cnt_x) begin
               dec_status = idq_pkg::ST_RANGE;
            end else begin
               dec_read = 1'b1;
            end
         end
         idq_pkg::OP_WRITE: begin
            if (is_empty) begin
               dec_status = idq_pkg::ST_EMPTY;
            end else if (pos_x >= cnt_x) begin
               dec_status = idq_pkg::ST_RANGE;
            end else begin
               dec_op = idq_pkg::CELL_WRITE;
            end
         end
         idq_pkg::OP_CLEAR: begin
            dec_count = '0;
         end
         default: begin
            dec_status = idq_pkg::ST_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         count_ff <= '0;
         wait_ff <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= (state_ff == EXEC);
         case (state_ff)
            IDLE: begin
               if (start) begin
                  status_ff <= dec_status;
                  act_ff <= dec_op;
                  pos_ff <= dec_pos;
                  word_ff <= req_word_in;
                  read_ff <= dec_read;
                  count_nxt_ff <= dec_count;
                  wait_ff <= '0;
                  state_ff <= dec_read ? GATHER : EXEC;
               end
            end
            GATHER: begin
               if (wait_ff == WAIT_W'(LAT - 1)) begin
                  state_ff <= EXEC;
               end else begin
                  wait_ff <= wait_ff + 1'b1;
               end
            end
            EXEC: begin
               count_ff <= count_nxt_ff;
               rsp_word_ff <= read_ff ? root_word : '0;
               rsp_status_ff <= status_ff;
               rsp_occupancy_ff <= count_nxt_ff;
               state_ff <= IDLE;
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   assign cmd.op = (state_ff == EXEC) ? act_ff : idq_pkg::CELL_HOLD;
   assign cmd.pos = pos_ff;

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [WORD_WIDTH-1:0] left_word;
      logic [WORD_WIDTH-1:0] right_word;

      if (g == 0) begin : g_first
         assign left_word = '0;
      end else begin : g_left
         assign left_word = cell_word[g-1];
      end

      if (g == CAPACITY - 1) begin : g_last
         assign right_word = '0;
      end else begin : g_right
         assign right_word = cell_word[g+1];
      end

      idq_cell #(
         .INDEX(g),
         .WORD_WIDTH(WORD_WIDTH)
      ) u_cell (
         .clock(clock),
         .cmd(cmd),
         .new_word(word_ff),
         .left_word(left_word),
         .right_word(right_word),
         .stored_word(cell_word[g]),
         .pick_word(pick_word[g])
      );
   end

   idq_gather #(
      .CAPACITY(CAPACITY),
      .WORD_WIDTH(WORD_WIDTH)
   ) u_gather (
      .clock(clock),
      .leaf_words(pick_word),
      .root_word(root_word)
   );

   assign busy = (state_ff != IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word_out = rsp_word_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_occupancy = rsp_occupancy_ff;

   a_strobe_after_exec: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == EXEC))
      else $error("result issued without an executed word");

   a_accept_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted word did not make the block busy");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("element count beyond capacity");

   a_full_only_at_capacity: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == idq_pkg::ST_FULL) |-> rsp_occupancy == CNT_W'(CAPACITY))
      else $error("full status reported below capacity");

   a_error_returns_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status != idq_pkg::ST_OK) |-> rsp_word_out == '0)
      else $error("error result carries a nonzero word");

endmodule
